@@ src/srgbl_pkg.sv @@
// Shared constants, types and the sRGB decode and threshold tables for the gray converter.
// No dependencies; the tables are built by constant functions at elaboration.
`default_nettype none

package srgbl_pkg;

  localparam int LIN_W    = 16;  // linear-light precision, Q0.LIN_W
  localparam int CH_W     = 8;   // sRGB code width
  localparam int WGT_W    = 16;  // Q0.16 weight width
  localparam int PROD_W   = LIN_W + WGT_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int CFG_IDX_W = 2;
  localparam int TAB_N    = 1 << CH_W;

  localparam logic [WGT_W-1:0] WEIGHT_RED_RST   = WGT_W'(13933);
  localparam logic [WGT_W-1:0] WEIGHT_GREEN_RST = WGT_W'(46871);
  localparam logic [WGT_W-1:0] WEIGHT_BLUE_RST  = WGT_W'(4732);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_RED   = 2'd0,
    REG_WEIGHT_GREEN = 2'd1,
    REG_WEIGHT_BLUE  = 2'd2
  } cfg_reg_t;

  typedef logic [LIN_W-1:0] lin_t;
  typedef logic [CH_W-1:0]  code_t;
  typedef lin_t [TAB_N-1:0] lin_tab_t;

  localparam lin_t LIN_MAX = {LIN_W{1'b1}};

  // y^5 in Q0.30 with truncating products
  function automatic logic [63:0] pow5_q30(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = (y * y) >> 30;
    y4 = (y2 * y2) >> 30;
    return (y4 * y) >> 30;
  endfunction

  // Linear value of sRGB level m/510, elaboration only
  function automatic lin_t srgb_to_lin(input logic [63:0] m);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    r = 64'd0;
    if (m <= 64'd20) begin
      r = (((m * 64'd100) << LIN_W) + 64'd329460) / 64'd658920;
    end else begin
      x  = ((64'd1000 * m + 64'd28050) << 30) / 64'd538050;
      x2 = (x * x) >> 30;
      lo = 64'd0;
      hi = 64'd1 << 30;
      // largest y with y^5 <= x^2, so the result is x^2 * x^0.4
      for (int i = 0; i < 40; i++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          if (pow5_q30(mid) <= x2) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      r = (x2 * lo + (64'd1 << (59 - LIN_W))) >> (60 - LIN_W);
    end
    if (r > 64'(LIN_MAX)) r = 64'(LIN_MAX);
    return LIN_W'(r);
  endfunction

  function automatic lin_tab_t build_decode();
    lin_tab_t t;
    for (int i = 0; i < TAB_N; i++) t[i] = srgb_to_lin(64'(2 * i));
    return t;
  endfunction

  // entry k is the linear value of code k-0.5; entry 0 is zero
  function automatic lin_tab_t build_thresh();
    lin_tab_t t;
    t[0] = '0;
    for (int i = 1; i < TAB_N; i++) t[i] = srgb_to_lin(64'(2 * i - 1));
    return t;
  endfunction

  localparam lin_tab_t DECODE_TAB = build_decode();
  localparam lin_tab_t THRESH_TAB = build_thresh();

endpackage

`default_nettype wire

@@ src/srgbl_encode.sv @@
// Pipelined sRGB re-encode: largest code whose midpoint threshold is <= the luminance.
// Depends on srgbl_pkg for the threshold table.
`default_nettype none

module srgbl_encode import srgbl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire lin_t  in_lum,
  output logic       out_valid,
  input  wire logic  out_ready,
  output code_t      out_gray
);

  localparam int NSTG = CH_W / 2;  // two code bits resolved per stage

  // thresholds are nondecreasing, so a bitwise search finds the count
  function automatic code_t try_bit(input code_t g, input lin_t y, input int b);
    code_t c;
    c = g | (code_t'(1) << b);
    return (THRESH_TAB[c] <= y) ? c : g;
  endfunction

  logic  v_r   [NSTG];
  code_t g_r   [NSTG];
  lin_t  y_r   [NSTG];
  logic  en    [NSTG+1];

  assign en[NSTG] = out_ready;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    code_t g_in;
    lin_t  y_in;
    logic  v_in;
    code_t g_nxt;

    if (s == 0) begin : g_first
      assign g_in = '0;
      assign y_in = in_lum;
      assign v_in = in_valid;
    end else begin : g_rest
      assign g_in = g_r[s-1];
      assign y_in = y_r[s-1];
      assign v_in = v_r[s-1];
    end

    assign en[s] = !v_r[s] || en[s+1];
    assign g_nxt = try_bit(try_bit(g_in, y_in, CH_W - 1 - 2 * s), y_in, CH_W - 2 - 2 * s);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_in;
      end
      if (en[s]) begin
        g_r[s] <= g_nxt;
        y_r[s] <= y_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];
  assign out_gray  = g_r[NSTG-1];

endmodule

`default_nettype wire

@@ src/srgb_linear_luma_grayscale_top.sv @@
// Top level of the sRGB to gray converter: weight registers, decode, weighting, luminance.
// Depends on srgbl_pkg and srgbl_encode.
`default_nettype none

// One sRGB pixel in, one sRGB gray code out, one pixel per clock sustained
// while out_ready is held high. A pixel passes through these stages in order:
// table decode, three 16x16 weight multiplies, sum with rounding and
// saturation, then four re-encode stages that each resolve two bits of the
// gray code against the midpoint threshold table. Each stage holds its beat
// on stall and bubbles are squeezed out, so while a finished result waits,
// input is still taken if any stage is empty. Weights are written through
// cfg_wr_en/cfg_index/cfg_wdata (0 red, 1 green, 2 blue, Q0.16, BT.709 after
// reset); index 3 is ignored. Write them only while the pipeline is empty.
module srgb_linear_luma_grayscale_top import srgbl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WGT_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CH_W-1:0]      in_red,
  input  wire logic [CH_W-1:0]      in_green,
  input  wire logic [CH_W-1:0]      in_blue,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CH_W-1:0]           out_gray
);

  logic [WGT_W-1:0] wr_r, wg_r, wb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= WEIGHT_RED_RST;
      wg_r <= WEIGHT_GREEN_RST;
      wb_r <= WEIGHT_BLUE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WEIGHT_RED:   wr_r <= cfg_wdata;
        REG_WEIGHT_GREEN: wg_r <= cfg_wdata;
        REG_WEIGHT_BLUE:  wb_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic              v1_r, v2_r, v3_r;
  logic              en1, en2, en3;
  logic              enc_ready;
  lin_t              lr_r, lg_r, lb_r;
  logic [PROD_W-1:0] pr_r, pg_r, pb_r;
  lin_t              lum_r;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-17:0] lum_wide;
  lin_t              lum_nxt;

  assign en3      = !v3_r || enc_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign sum = SUM_W'(pr_r) + SUM_W'(pg_r) + SUM_W'(pb_r) + SUM_W'(32768);
  assign lum_wide = sum[SUM_W-1:16];
  assign lum_nxt  = (lum_wide > (SUM_W-16)'(LIN_MAX)) ? LIN_MAX : LIN_W'(lum_wide);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
    if (en1) begin
      lr_r <= DECODE_TAB[in_red];
      lg_r <= DECODE_TAB[in_green];
      lb_r <= DECODE_TAB[in_blue];
    end
    if (en2) begin
      pr_r <= PROD_W'(wr_r) * PROD_W'(lr_r);
      pg_r <= PROD_W'(wg_r) * PROD_W'(lg_r);
      pb_r <= PROD_W'(wb_r) * PROD_W'(lb_r);
    end
    if (en3) lum_r <= lum_nxt;
  end

  srgbl_encode u_encode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (enc_ready),
    .in_lum    (lum_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_gray  (out_gray)
  );

  // front stages come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r)
    else $error("front pipeline not empty after reset");

  // input backs up only when every front stage is full and the encoder is blocked
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && !enc_ready)
    else $error("input stalled with room in the pipeline");

  // a stalled luminance beat is neither dropped nor altered
  a_lum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !enc_ready |=> v3_r && $stable(lum_r))
    else $error("stalled luminance beat lost");

endmodule

`default_nettype wire
